FILE: rtl/trz_pkg.sv
package trz_pkg;

    localparam int MaxWidth  = 128;
    localparam int MaxHeight = 128;
    localparam int StoreSize = MaxWidth * MaxHeight;
    localparam int AddrW     = $clog2(StoreSize);
    localparam int CoordW    = 13;
    localparam int CountW    = 15;
    localparam logic [CountW-1:0] CountLimit = 15'd32767;

    localparam logic [1:0] OpDraw  = 2'd0;
    localparam logic [1:0] OpClear = 2'd1;
    localparam logic [1:0] OpRead  = 2'd2;

    localparam logic [1:0] StDone     = 2'd0;
    localparam logic [1:0] StEmpty    = 2'd1;
    localparam logic [1:0] StDegen    = 2'd2;
    localparam logic [1:0] StBadIndex = 2'd3;

    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegClear  = 2'd2;

    // Job kinds handed from the front part to the back part.
    localparam logic [1:0] JobNone  = 2'd0;
    localparam logic [1:0] JobDraw  = 2'd1;
    localparam logic [1:0] JobClear = 2'd2;
    localparam logic [1:0] JobRead  = 2'd3;

    typedef struct packed {
        logic [1:0]                kind;
        logic [1:0]                status;
        logic signed [CoordW-1:0]  ax, ay, bx, by, cx, cy;
        logic [10:0]               minx, maxx, miny, maxy;
        logic [31:0]               depth;
        logic [7:0]                color;
        logic [AddrW-1:0]          index;
    } job_t;

endpackage

FILE: rtl/trz_ram.sv
module trz_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/trz_front.sv
module trz_front import trz_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic signed [12:0] x0, y0, x1, y1, x2, y2,
    input  logic [31:0] z0, z1, z2,
    input  logic [7:0]  fill_color,
    input  logic [13:0] pixel_index,
    input  logic [7:0]  eff_w,
    input  logic [7:0]  eff_h,
    output logic        job_valid,
    input  logic        job_take,
    output job_t        job
);
    // Stage 1 registers the item with each z already divided by 3;
    // stage 2 computes box, area, depth.
    logic        s1_reg;
    logic [1:0]  op_reg;
    logic signed [12:0] vx_reg [3];
    logic signed [12:0] vy_reg [3];
    logic [31:0] vz_reg [3];
    logic [7:0]  col_reg;
    logic [13:0] idx_reg;
    logic        s1_next;
    logic        jv_reg;
    job_t        job_reg;

    assign in_stall  = s1_reg;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    // Stage 1 -> 2 moves when the job register is free.
    logic move;
    assign move = s1_reg && (!jv_reg || job_take);

    // Divide by 3 through the reciprocal: (v * 0xAAAAAAAB) >> 33.
    function automatic logic [31:0] div3(input logic [31:0] v);
        logic [63:0] p;
        p = 64'(v) * 64'(32'hAAAA_AAAB);
        return {1'b0, p[63:33]};
    endfunction

    always_comb
    begin
        s1_next = s1_reg;
        if (move)
        begin
            s1_next = 1'b0;
        end
        if (in_valid && !in_stall)
        begin
            s1_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0;
            jv_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= s1_next;
            if (move)
            begin
                jv_reg <= 1'b1;
            end
            else if (job_take)
            begin
                jv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg    <= opcode;
            vx_reg[0] <= x0; vy_reg[0] <= y0; vz_reg[0] <= div3(z0);
            vx_reg[1] <= x1; vy_reg[1] <= y1; vz_reg[1] <= div3(z1);
            vx_reg[2] <= x2; vy_reg[2] <= y2; vz_reg[2] <= div3(z2);
            col_reg   <= fill_color;
            idx_reg   <= pixel_index;
        end
    end

    // Classification.
    logic signed [13:0] mnx, mxx, mny, mxy;
    logic signed [13:0] cminx, cmaxx, cminy, cmaxy;
    logic signed [27:0] area;
    logic [31:0] tz;
    logic [15:0] npix;
    job_t        nj;

    function automatic logic signed [13:0] min3(input logic signed [12:0] a, b, c);
        logic signed [12:0] m;
        m = (a < b) ? a : b;
        return 14'(signed'(((c < m) ? c : m)));
    endfunction

    function automatic logic signed [13:0] max3(input logic signed [12:0] a, b, c);
        logic signed [12:0] m;
        m = (a > b) ? a : b;
        return 14'(signed'(((c > m) ? c : m)));
    endfunction

    always_comb
    begin
        mnx = min3(vx_reg[0], vx_reg[1], vx_reg[2]);
        mxx = max3(vx_reg[0], vx_reg[1], vx_reg[2]);
        mny = min3(vy_reg[0], vy_reg[1], vy_reg[2]);
        mxy = max3(vy_reg[0], vy_reg[1], vy_reg[2]);
        cminx = (mnx < 0) ? 14'sd0 : mnx;
        cminy = (mny < 0) ? 14'sd0 : mny;
        cmaxx = (mxx >= $signed({6'd0, eff_w})) ? $signed({6'd0, eff_w}) - 14'sd1 : mxx;
        cmaxy = (mxy >= $signed({6'd0, eff_h})) ? $signed({6'd0, eff_h}) - 14'sd1 : mxy;
        area = (28'(vx_reg[2]) - 28'(vx_reg[0])) * (28'(vy_reg[1]) - 28'(vy_reg[0]))
             - (28'(vy_reg[2]) - 28'(vy_reg[0])) * (28'(vx_reg[1]) - 28'(vx_reg[0]));
        tz = vz_reg[0] + vz_reg[1] + vz_reg[2];
        npix = 16'(eff_w) * 16'(eff_h);

        nj        = '0;
        nj.ax     = vx_reg[0];
        nj.ay     = vy_reg[0];
        nj.bx     = area < 0 ? vx_reg[2] : vx_reg[1];
        nj.by     = area < 0 ? vy_reg[2] : vy_reg[1];
        nj.cx     = area < 0 ? vx_reg[1] : vx_reg[2];
        nj.cy     = area < 0 ? vy_reg[1] : vy_reg[2];
        nj.minx   = cminx[10:0];
        nj.maxx   = cmaxx[10:0];
        nj.miny   = cminy[10:0];
        nj.maxy   = cmaxy[10:0];
        nj.depth  = tz;
        nj.color  = col_reg;
        nj.index  = idx_reg[AddrW-1:0];
        nj.status = StDone;
        unique case (op_reg)
            OpDraw:
            begin
                if (cminx > cmaxx || cminy > cmaxy)
                begin
                    nj.kind = JobNone; nj.status = StEmpty;
                end
                else if (area == 0)
                begin
                    nj.kind = JobNone; nj.status = StDegen;
                end
                else
                begin
                    nj.kind = JobDraw;
                end
            end
            OpClear: nj.kind = JobClear;
            OpRead:
            begin
                if (16'(idx_reg) >= npix)
                begin
                    nj.kind = JobNone; nj.status = StBadIndex;
                end
                else
                begin
                    nj.kind = JobRead;
                end
            end
            default: nj.kind = JobNone;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            job_reg <= nj;
        end
    end
endmodule

FILE: rtl/trz_back.sv
module trz_back import trz_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_take,
    input  job_t        job,
    input  logic [7:0]  eff_w,
    input  logic [7:0]  eff_h,
    input  logic [31:0] clear_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [14:0] pixels_written,
    output logic [7:0]  read_color,
    output logic [31:0] read_depth
);
    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_TEST  = 7'b0001000,
        S_CLEAR = 7'b0010000,
        S_READ  = 7'b0100000,
        S_RDOUT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    job_t   cur_reg;
    logic [10:0] x_reg, y_reg;
    logic [AddrW:0] cnt_reg;
    logic [CountW-1:0] wc_reg;
    logic ov_reg;
    logic [1:0] st_reg;
    logic [14:0] pw_reg;
    logic [7:0] rc_reg;
    logic [31:0] rd_reg;

    // Test pipeline: address and coverage registered together with the RAM read.
    logic t_reg;
    logic [AddrW-1:0] ta_reg;
    logic last_reg;

    logic [AddrW-1:0] raddr, waddr;
    logic we_c, we_z;
    logic [7:0]  cdata, crd;
    logic [31:0] zdata, zrd;

    assign out_valid      = ov_reg;
    assign status         = st_reg;
    assign pixels_written = pw_reg;
    assign read_color     = rc_reg;
    assign read_depth     = rd_reg;

    logic out_free;
    assign out_free = !ov_reg || !out_stall;
    assign job_take = (state_reg == S_IDLE) && job_valid && out_free;

    // Edge functions at current pixel.
    logic signed [27:0] e0, e1, e2, px, py;
    always_comb
    begin
        px = 28'($signed({1'b0, x_reg}));
        py = 28'($signed({1'b0, y_reg}));
        e0 = (px - 28'(cur_reg.bx)) * (28'(cur_reg.cy) - 28'(cur_reg.by))
           - (py - 28'(cur_reg.by)) * (28'(cur_reg.cx) - 28'(cur_reg.bx));
        e1 = (px - 28'(cur_reg.cx)) * (28'(cur_reg.ay) - 28'(cur_reg.cy))
           - (py - 28'(cur_reg.cy)) * (28'(cur_reg.ax) - 28'(cur_reg.cx));
        e2 = (px - 28'(cur_reg.ax)) * (28'(cur_reg.by) - 28'(cur_reg.ay))
           - (py - 28'(cur_reg.ay)) * (28'(cur_reg.bx) - 28'(cur_reg.ax));
    end

    logic [18:0] addr_full;
    logic        inside_px, last_px, pass;
    assign addr_full = 19'(y_reg) * 19'(eff_w) + 19'(x_reg);
    assign inside_px = (e0 >= 0) && (e1 >= 0) && (e2 >= 0) && (addr_full < 19'(StoreSize));
    assign last_px   = (x_reg == cur_reg.maxx) && (y_reg == cur_reg.maxy);
    assign pass      = t_reg && (cur_reg.depth < zrd);

    logic [AddrW:0] n_clear;
    assign n_clear = (AddrW+1)'(16'(eff_w) * 16'(eff_h));

    // Raise the result beat when a job finishes.
    logic ov_set;
    always_comb
    begin
        ov_set = 1'b0;
        if (state_reg == S_IDLE)
        begin
            ov_set = job_take && (job.kind == JobNone);
        end
        else if (state_reg == S_TEST)
        begin
            ov_set = last_reg && out_free;
        end
        else if (state_reg == S_CLEAR)
        begin
            ov_set = (cnt_reg >= n_clear) && out_free;
        end
        else if (state_reg == S_RDOUT)
        begin
            ov_set = out_free;
        end
    end

    always_comb
    begin
        raddr = (state_reg == S_IDLE) ? job.index : addr_full[AddrW-1:0];
        waddr = ta_reg;
        we_c  = 1'b0;
        we_z  = 1'b0;
        cdata = cur_reg.color;
        zdata = cur_reg.depth;
        if (state_reg == S_INIT)
        begin
            waddr = cnt_reg[AddrW-1:0];
            we_c  = 1'b1;
            we_z  = 1'b1;
            cdata = 8'd0;
            zdata = 32'hFFFF_FFFF;
        end
        else if (state_reg == S_CLEAR)
        begin
            waddr = cnt_reg[AddrW-1:0];
            we_z  = cnt_reg < n_clear;
            zdata = clear_value;
        end
        else if (state_reg == S_TEST)
        begin
            we_c = pass;
            we_z = pass;
        end
    end

    trz_ram #(.Width(8), .Depth(StoreSize)) u_color (
        .clk(clk), .we(we_c), .waddr(waddr), .wdata(cdata), .raddr(raddr), .rdata(crd)
    );
    trz_ram #(.Width(32), .Depth(StoreSize)) u_depth (
        .clk(clk), .we(we_z), .waddr(waddr), .wdata(zdata), .raddr(raddr), .rdata(zrd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:  if (cnt_reg == (AddrW+1)'(StoreSize - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (job_take)
                begin
                    unique case (job.kind)
                        JobDraw:  state_next = S_SCAN;
                        JobClear: state_next = S_CLEAR;
                        JobRead:  state_next = S_READ;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:  state_next = S_TEST;
            // Alternate scan and test, one pixel each pair, avoiding RAW hazards.
            S_TEST:  state_next = (last_reg && out_free) ? S_IDLE : (last_reg ? S_TEST : S_SCAN);
            S_CLEAR:
            begin
                if (cnt_reg >= n_clear && out_free) state_next = S_IDLE;
            end
            S_READ:  state_next = S_RDOUT;
            S_RDOUT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            t_reg     <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_set || (ov_reg && out_stall);
            unique case (state_reg)
                S_INIT: cnt_reg <= cnt_reg + 1'b1;
                S_IDLE: cnt_reg <= '0;
                S_SCAN:
                begin
                    t_reg    <= inside_px;
                    last_reg <= last_px;
                end
                S_TEST:
                begin
                    t_reg <= 1'b0;
                    if (last_reg && out_free)
                    begin
                        last_reg <= 1'b0;
                    end
                end
                S_CLEAR:
                begin
                    if (cnt_reg < n_clear)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_READ: ;
                S_RDOUT: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            cur_reg <= job;
            x_reg   <= job.minx;
            y_reg   <= job.miny;
            wc_reg  <= '0;
            st_reg  <= job.status;
            pw_reg  <= '0;
            rc_reg  <= '0;
            rd_reg  <= '0;
        end
        if (state_reg == S_SCAN)
        begin
            ta_reg <= addr_full[AddrW-1:0];
            if (x_reg == cur_reg.maxx)
            begin
                x_reg <= cur_reg.minx;
                y_reg <= y_reg + 1'b1;
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end
        if (state_reg == S_TEST)
        begin
            if (pass && wc_reg != CountLimit)
            begin
                wc_reg <= wc_reg + 1'b1;
                pw_reg <= wc_reg + 1'b1;
            end
            else
            begin
                pw_reg <= wc_reg;
            end
        end
        // Read data from the take edge is only valid in this state.
        if (state_reg == S_READ)
        begin
            rc_reg <= crd;
            rd_reg <= zrd;
        end
    end
endmodule

FILE: rtl/triangle_rasterizer_zbuffer_core.sv
// From the accepting edge to out_valid, back part idle: a draw scans then tests
// each clipped box pixel; a clear sweeps W*H depth entries; a read fetches the
// entry, then presents it; rejected items report when the back part takes them.
// The back part handles one item at a time; for draws the box scan (scan, then depth read-modify-write) sets the pace.
// Reset: registers take reset values, then both stores are swept one entry per
// cycle, all 16384 entries, before the first item is taken.
module triangle_rasterizer_zbuffer_core import trz_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic signed [12:0] x0,
    input  logic signed [12:0] y0,
    input  logic [31:0] z0,
    input  logic signed [12:0] x1,
    input  logic signed [12:0] y1,
    input  logic [31:0] z1,
    input  logic signed [12:0] x2,
    input  logic signed [12:0] y2,
    input  logic [31:0] z2,
    input  logic [7:0]  fill_color,
    input  logic [13:0] pixel_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [14:0] pixels_written,
    output logic [7:0]  read_color,
    output logic [31:0] read_depth,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [7:0]  aw_reg, ah_reg;
    logic [31:0] cd_reg;
    logic [7:0]  eff_w, eff_h;
    logic        jv, jt;
    job_t        jb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg <= 8'd128;
            ah_reg <= 8'd128;
            cd_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegWidth:  aw_reg <= cfg_data[7:0];
                RegHeight: ah_reg <= cfg_data[7:0];
                RegClear:  cd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_w = (9'(aw_reg) > 9'(MaxWidth))  ? 8'(MaxWidth)  : aw_reg;
    assign eff_h = (9'(ah_reg) > 9'(MaxHeight)) ? 8'(MaxHeight) : ah_reg;

    trz_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .x0(x0), .y0(y0), .x1(x1), .y1(y1), .x2(x2), .y2(y2),
        .z0(z0), .z1(z1), .z2(z2), .fill_color(fill_color),
        .pixel_index(pixel_index), .eff_w(eff_w), .eff_h(eff_h),
        .job_valid(jv), .job_take(jt), .job(jb)
    );

    trz_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_take(jt), .job(jb),
        .eff_w(eff_w), .eff_h(eff_h), .clear_value(cd_reg),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .pixels_written(pixels_written), .read_color(read_color),
        .read_depth(read_depth)
    );
endmodule
